[hw/rtl/lps_pkg.sv]
// lps_pkg: shared constants for the line pixel stepper
// field widths, register indexes, reset values and item opcodes
// no dependencies
package lps_pkg;

  // coordinate width default, range 8 to 16
  localparam int unsigned COORD_BITS_DEF = 12;

  // fixed field widths
  localparam int unsigned ROW_PITCH_W = 16;
  localparam int unsigned BPP_W       = 4;
  localparam int unsigned FRAME_W     = 12;
  localparam int unsigned COLOR_W     = 24;
  localparam int unsigned ADDR_W      = 28;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROW_PITCH       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BYTES_PER_PIXEL = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DRAW_COLOR      = 3'd4;

  // register reset values
  localparam logic [ROW_PITCH_W-1:0] ROW_PITCH_RST    = 16'd0;
  localparam logic [BPP_W-1:0]       BPP_RST          = 4'd4;
  localparam logic [FRAME_W-1:0]     FRAME_WIDTH_RST  = 12'd1024;
  localparam logic [FRAME_W-1:0]     FRAME_HEIGHT_RST = 12'd768;
  localparam logic [COLOR_W-1:0]     DRAW_COLOR_RST   = 24'hFFFFFF;

  // item opcodes
  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

endpackage

[hw/rtl/lps_if.sv]
// lps_if: valid/ready channels of the line pixel stepper
// command, pixel result and configuration write channels
// depends on lps_pkg
interface lps_cmd_if #(
  parameter int unsigned COORD_BITS = lps_pkg::COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic                         op;
  logic signed [COORD_BITS-1:0] start_x;
  logic signed [COORD_BITS-1:0] start_y;
  logic signed [COORD_BITS-1:0] end_x;
  logic signed [COORD_BITS-1:0] end_y;

  modport source (output valid, op, start_x, start_y, end_x, end_y, input ready);
  modport sink   (input valid, op, start_x, start_y, end_x, end_y, output ready);
endinterface

interface lps_pix_if #(
  parameter int unsigned COORD_BITS = lps_pkg::COORD_BITS_DEF
);
  logic                               valid;
  logic                               ready;
  logic signed [COORD_BITS-1:0]       pixel_x;
  logic signed [COORD_BITS-1:0]       pixel_y;
  logic [lps_pkg::ADDR_W-1:0]         pixel_address;
  logic [lps_pkg::COLOR_W-1:0]        pixel_color;
  logic                               in_frame;
  logic                               last_pixel;

  modport source (output valid, pixel_x, pixel_y, pixel_address, pixel_color, in_frame,
                  last_pixel, input ready);
  modport sink   (input valid, pixel_x, pixel_y, pixel_address, pixel_color, in_frame,
                  last_pixel, output ready);
endinterface

interface lps_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [lps_pkg::CFG_IDX_W-1:0]  index;
  logic [lps_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[hw/rtl/line_pixel_stepper_unit.sv]
// line_pixel_stepper_unit: bresenham line stepper with frame buffer addressing
// items pass stage 1 and the output register, one item per cycle while pix.ready is high
// stage 1 is the bresenham state register, stage 2 the address multiply and output register
// the output register takes a new pixel whenever it is empty or drained in the same cycle
// rst (synchronous) clears the line state and both valid flags, config returns to defaults
// depends on lps_pkg and the lps_if channel interfaces
module line_pixel_stepper_unit #(
  parameter int unsigned COORD_BITS = lps_pkg::COORD_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst,
  lps_cmd_if.sink  cmd,
  lps_pix_if.source pix,
  lps_cfg_if.sink  cfg
);

  localparam int unsigned ERR_W = COORD_BITS + 3;
  localparam int unsigned CMP_W =
    ((COORD_BITS > lps_pkg::FRAME_W) ? COORD_BITS : lps_pkg::FRAME_W) + 1;
  localparam int unsigned PY_W  = COORD_BITS + lps_pkg::ROW_PITCH_W;
  localparam int unsigned PX_W  = COORD_BITS + lps_pkg::BPP_W;
  localparam int unsigned SUM_W =
    ((PY_W + 1) > lps_pkg::ADDR_W) ? (PY_W + 1) : lps_pkg::ADDR_W;

  // configuration registers
  logic [lps_pkg::ROW_PITCH_W-1:0]  row_pitch;
  logic [lps_pkg::BPP_W-1:0]        bytes_per_pixel;
  logic [lps_pkg::FRAME_W-1:0]      frame_width;
  logic [lps_pkg::FRAME_W-1:0]      frame_height;
  logic [lps_pkg::COLOR_W-1:0]      draw_color;

  // line state
  logic signed [COORD_BITS-1:0] cur_x, cur_x_next;
  logic signed [COORD_BITS-1:0] cur_y, cur_y_next;
  logic signed [ERR_W-1:0]      err_term, err_term_next;
  logic [COORD_BITS-1:0]        abs_dx, abs_dx_next;
  logic [COORD_BITS-1:0]        abs_dy, abs_dy_next;
  logic [COORD_BITS-1:0]        steps_left, steps_left_next;
  logic                         dir_x_neg, dir_x_neg_next;
  logic                         dir_y_neg, dir_y_neg_next;
  logic                         x_major, x_major_next;

  // pipeline control
  logic s1_valid;
  logic out_valid;
  logic cmd_take;
  logic out_load;

  // start setup
  logic signed [COORD_BITS:0]   dx_w, dy_w;
  logic                         st_xneg, st_yneg, st_xmaj;
  logic [COORD_BITS-1:0]        st_adx, st_ady, st_major, st_minor;

  // step datapath
  logic [COORD_BITS-1:0]        major, minor;
  logic signed [ERR_W-1:0]      major_e, minor_e;
  logic signed [COORD_BITS-1:0] step_x, step_y;

  // emit datapath
  logic                         in_view;
  logic [PY_W-1:0]              prod_y;
  logic [PX_W-1:0]              prod_x;
  logic [SUM_W-1:0]             addr_sum;

  // handshake
  assign cfg.ready = 1'b1;
  assign out_load  = s1_valid && (!out_valid || pix.ready);
  assign cmd.ready = !s1_valid || out_load;
  assign cmd_take  = cmd.valid && cmd.ready;
  assign pix.valid = out_valid;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      row_pitch       <= lps_pkg::ROW_PITCH_RST;
      bytes_per_pixel <= lps_pkg::BPP_RST;
      frame_width     <= lps_pkg::FRAME_WIDTH_RST;
      frame_height    <= lps_pkg::FRAME_HEIGHT_RST;
      draw_color      <= lps_pkg::DRAW_COLOR_RST;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        lps_pkg::REG_ROW_PITCH:       row_pitch       <= cfg.data[lps_pkg::ROW_PITCH_W-1:0];
        lps_pkg::REG_BYTES_PER_PIXEL: bytes_per_pixel <= cfg.data[lps_pkg::BPP_W-1:0];
        lps_pkg::REG_FRAME_WIDTH:     frame_width     <= cfg.data[lps_pkg::FRAME_W-1:0];
        lps_pkg::REG_FRAME_HEIGHT:    frame_height    <= cfg.data[lps_pkg::FRAME_W-1:0];
        lps_pkg::REG_DRAW_COLOR:      draw_color      <= cfg.data[lps_pkg::COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  // start: direction, magnitudes and major axis
  always_comb begin
    st_xneg  = cmd.end_x < cmd.start_x;
    st_yneg  = cmd.end_y < cmd.start_y;
    dx_w     = st_xneg ? ((COORD_BITS+1)'(cmd.start_x) - (COORD_BITS+1)'(cmd.end_x))
                       : ((COORD_BITS+1)'(cmd.end_x) - (COORD_BITS+1)'(cmd.start_x));
    dy_w     = st_yneg ? ((COORD_BITS+1)'(cmd.start_y) - (COORD_BITS+1)'(cmd.end_y))
                       : ((COORD_BITS+1)'(cmd.end_y) - (COORD_BITS+1)'(cmd.start_y));
    st_adx   = dx_w[COORD_BITS-1:0];
    st_ady   = dy_w[COORD_BITS-1:0];
    st_xmaj  = st_adx > st_ady;
    st_major = st_xmaj ? st_adx : st_ady;
    st_minor = st_xmaj ? st_ady : st_adx;
  end

  // step: one pixel along the major axis, minor axis when the error allows
  always_comb begin
    major   = x_major ? abs_dx : abs_dy;
    minor   = x_major ? abs_dy : abs_dx;
    major_e = signed'(ERR_W'(major));
    minor_e = signed'(ERR_W'(minor));
    step_x  = dir_x_neg ? cur_x - COORD_BITS'(1) : cur_x + COORD_BITS'(1);
    step_y  = dir_y_neg ? cur_y - COORD_BITS'(1) : cur_y + COORD_BITS'(1);
  end

  // next line state
  always_comb begin
    cur_x_next      = cur_x;
    cur_y_next      = cur_y;
    err_term_next   = err_term;
    abs_dx_next     = abs_dx;
    abs_dy_next     = abs_dy;
    steps_left_next = steps_left;
    dir_x_neg_next  = dir_x_neg;
    dir_y_neg_next  = dir_y_neg;
    x_major_next    = x_major;
    if (cmd_take) begin
      if (cmd.op == lps_pkg::OP_START) begin
        cur_x_next      = cmd.start_x;
        cur_y_next      = cmd.start_y;
        abs_dx_next     = st_adx;
        abs_dy_next     = st_ady;
        dir_x_neg_next  = st_xneg;
        dir_y_neg_next  = st_yneg;
        x_major_next    = st_xmaj;
        steps_left_next = st_major;
        err_term_next   = (signed'(ERR_W'(st_minor)) <<< 1) - signed'(ERR_W'(st_major));
      end else if (steps_left != '0) begin
        steps_left_next = steps_left - COORD_BITS'(1);
        if (!err_term[ERR_W-1]) begin
          err_term_next = err_term + ((minor_e - major_e) <<< 1);
          cur_x_next    = step_x;
          cur_y_next    = step_y;
        end else begin
          err_term_next = err_term + (minor_e <<< 1);
          if (x_major) begin
            cur_x_next = step_x;
          end else begin
            cur_y_next = step_y;
          end
        end
      end
    end
  end

  // stage 1: line state and its valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_x      <= '0;
      cur_y      <= '0;
      err_term   <= '0;
      abs_dx     <= '0;
      abs_dy     <= '0;
      steps_left <= '0;
      dir_x_neg  <= 1'b0;
      dir_y_neg  <= 1'b0;
      x_major    <= 1'b0;
      s1_valid   <= 1'b0;
    end else begin
      cur_x      <= cur_x_next;
      cur_y      <= cur_y_next;
      err_term   <= err_term_next;
      abs_dx     <= abs_dx_next;
      abs_dy     <= abs_dy_next;
      steps_left <= steps_left_next;
      dir_x_neg  <= dir_x_neg_next;
      dir_y_neg  <= dir_y_neg_next;
      x_major    <= x_major_next;
      if (cmd_take) begin
        s1_valid <= 1'b1;
      end else if (out_load) begin
        s1_valid <= 1'b0;
      end
    end
  end

  // stage 2: frame check and byte address of the current pixel
  always_comb begin
    in_view  = !cur_x[COORD_BITS-1] && !cur_y[COORD_BITS-1] &&
               (CMP_W'(unsigned'(cur_x)) < CMP_W'(frame_width)) &&
               (CMP_W'(unsigned'(cur_y)) < CMP_W'(frame_height));
    prod_y   = PY_W'(unsigned'(cur_y)) * PY_W'(row_pitch);
    prod_x   = PX_W'(unsigned'(cur_x)) * PX_W'(bytes_per_pixel);
    addr_sum = SUM_W'(prod_y) + SUM_W'(prod_x);
  end

  // output register, the line is at its end point exactly when no steps remain
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (pix.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      pix.pixel_x       <= cur_x;
      pix.pixel_y       <= cur_y;
      pix.pixel_address <= in_view ? addr_sum[lps_pkg::ADDR_W-1:0] : '0;
      pix.pixel_color   <= draw_color;
      pix.in_frame      <= in_view;
      pix.last_pixel    <= (steps_left == '0);
    end
  end

endmodule
